// ===== hw/rtl/postfix_expression_evaluator_defines.svh =====
// Assertion helpers for the postfix evaluator checker
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// clocked check, off while reset is asserted
`define PFE_ASSERT(name_, prop_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) \
    else $error(msg_);

// clocked check that also holds during reset
`define PFE_ASSERT_RST(name_, prop_, msg_) \
  name_: assert property (@(posedge clk_i) (prop_)) \
    else $error(msg_);

`endif

// ===== hw/rtl/pfe_pkg.sv =====
package pfe_pkg;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_PAREN  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    status_e                 status;
  } out_item_t;

  // first error of an expression sticks
  function automatic status_e note_err(status_e cur, status_e code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

// ===== hw/rtl/pfe_stream_if.sv =====
interface pfe_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator. Characters arrive one per transaction on in_i; a digit
// pushes 0..9 onto a STACK_DEPTH-entry stack of 32-bit values, + - * / combine the top
// two entries (wrapping arithmetic, division truncates toward zero), parentheses flag an
// error and everything else is ignored. The character marked last produces one result on
// out_o: the top of stack with status OK, or value 0 with the first error seen. The stack
// is an internal memory with one read and one write port, and all arithmetic runs through
// one shared 34-bit adder, one bit per cycle for multiply and divide. in_i is ready only
// between characters (in IDLE, which takes a digit or an ignored character); + and - pass
// through RDR, RDL, SETUP and WB, * adds 32 shift-add steps in MUL, / adds NEGL, NEGR, 32
// restoring-divide steps in DIV and FIXQ. A last character then reads the top in FIN and
// loads the output register in EMIT, where it waits while an earlier result is not taken.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfe_stream_if.sink          in_i,
  pfe_stream_if.source        out_o
);
  import pfe_pkg::*;

  localparam int unsigned PtrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_RDR   = 12'b0000_0000_0010,
    S_RDL   = 12'b0000_0000_0100,
    S_SETUP = 12'b0000_0000_1000,
    S_MUL   = 12'b0000_0001_0000,
    S_NEGL  = 12'b0000_0010_0000,
    S_NEGR  = 12'b0000_0100_0000,
    S_DIV   = 12'b0000_1000_0000,
    S_FIXQ  = 12'b0001_0000_0000,
    S_WB    = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  status_e         err_q, err_d;
  logic [4:0]      it_q, it_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  op_e             op_q, op_d;
  logic            last_q, last_d;
  logic            neg_q, neg_d;
  logic [DataW-1:0] l_q, l_d, r_q, r_d, acc_q, acc_d;

  logic [DataW-1:0] stack_mem [STACK_DEPTH];
  logic [DataW-1:0] rd_data_q;
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr, rd_addr;
  logic [DataW-1:0] wr_data;

  logic [DataW:0]   alu_a, alu_b;
  logic             alu_sub;
  logic [DataW+1:0] alu_sum;

  logic [CntW-1:0] cnt_m1, cnt_m2;
  logic [7:0]      sym, dig;
  logic            is_digit, is_op, is_paren;
  op_e             op_dec;
  state_e          acc_done, end_state;
  status_e         fin_status;

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (DataW+2)'(alu_sub);

  assign cnt_m1 = cnt_q - CntW'(1);
  assign cnt_m2 = cnt_q - CntW'(2);

  assign sym      = in_i.payload.symbol;
  assign dig      = sym - CH_0;
  assign is_digit = (sym >= CH_0) && (sym <= CH_9);
  assign is_paren = (sym == CH_LPAREN) || (sym == CH_RPAREN);
  assign is_op    = (sym == CH_PLUS) || (sym == CH_MINUS) ||
                    (sym == CH_STAR) || (sym == CH_SLASH);

  always_comb begin
    priority if (sym == CH_PLUS) begin
      op_dec = OP_ADD;
    end else if (sym == CH_MINUS) begin
      op_dec = OP_SUB;
    end else if (sym == CH_STAR) begin
      op_dec = OP_MUL;
    end else begin
      op_dec = OP_DIV;
    end
  end

  assign acc_done  = in_i.payload.last ? S_FIN : S_IDLE;
  assign end_state = last_q ? S_FIN : S_IDLE;

  // empty stack at the end counts as underflow unless an earlier error stuck
  assign fin_status = (err_q != ST_OK) ? err_q :
                      ((cnt_q == '0) ? ST_UNDER : ST_OK);

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    it_d        = it_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    op_d        = op_q;
    last_d      = last_q;
    neg_d       = neg_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[PtrW-1:0];
    wr_data     = acc_q;
    rd_addr     = cnt_m1[PtrW-1:0];
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          last_d  = in_i.payload.last;
          state_d = acc_done;
          priority if (is_digit) begin
            if (cnt_q >= CntW'(STACK_DEPTH)) begin
              err_d = note_err(err_q, ST_OVER);
            end else begin
              wr_en   = 1'b1;
              wr_data = {{(DataW-8){1'b0}}, dig};
              cnt_d   = cnt_q + CntW'(1);
            end
          end else if (is_op) begin
            if (cnt_q < CntW'(2)) begin
              err_d = note_err(err_q, ST_UNDER);
            end else begin
              op_d    = op_dec;
              state_d = S_RDR;
            end
          end else if (is_paren) begin
            err_d = note_err(err_q, ST_PAREN);
          end else begin
            err_d = err_q;
          end
        end
      end
      S_RDR: begin
        state_d = S_RDL;
      end
      S_RDL: begin
        rd_addr = cnt_m2[PtrW-1:0];
        r_d     = rd_data_q;
        state_d = S_SETUP;
      end
      S_SETUP: begin
        l_d     = rd_data_q;
        alu_a   = {1'b0, rd_data_q};
        alu_b   = {1'b0, r_q};
        alu_sub = (op_q == OP_SUB);
        it_d    = '0;
        unique case (op_q)
          OP_ADD, OP_SUB: begin
            acc_d   = alu_sum[DataW-1:0];
            state_d = S_WB;
          end
          OP_MUL: begin
            acc_d   = '0;
            state_d = S_MUL;
          end
          default: begin
            if (r_q == '0) begin
              err_d   = note_err(err_q, ST_DIVZ);
              state_d = end_state;
            end else begin
              neg_d   = rd_data_q[DataW-1] ^ r_q[DataW-1];
              state_d = S_NEGL;
            end
          end
        endcase
      end
      S_MUL: begin
        alu_a = {1'b0, acc_q};
        alu_b = {1'b0, l_q};
        if (r_q[0]) begin
          acc_d = alu_sum[DataW-1:0];
        end
        l_d  = {l_q[DataW-2:0], 1'b0};
        r_d  = {1'b0, r_q[DataW-1:1]};
        it_d = it_q + 5'd1;
        if (it_q == '1) begin
          state_d = S_WB;
        end
      end
      S_NEGL: begin
        alu_b   = {1'b0, l_q};
        alu_sub = 1'b1;
        if (l_q[DataW-1]) begin
          l_d = alu_sum[DataW-1:0];
        end
        state_d = S_NEGR;
      end
      S_NEGR: begin
        alu_b   = {1'b0, r_q};
        alu_sub = 1'b1;
        if (r_q[DataW-1]) begin
          r_d = alu_sum[DataW-1:0];
        end
        acc_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring step: acc is the partial remainder, l shifts in quotient bits
        alu_a   = {acc_q, l_q[DataW-1]};
        alu_b   = {1'b0, r_q};
        alu_sub = 1'b1;
        acc_d   = alu_sum[DataW+1] ? alu_sum[DataW-1:0] : alu_a[DataW-1:0];
        l_d     = {l_q[DataW-2:0], alu_sum[DataW+1]};
        it_d    = it_q + 5'd1;
        if (it_q == '1) begin
          state_d = S_FIXQ;
        end
      end
      S_FIXQ: begin
        alu_b   = {1'b0, l_q};
        alu_sub = 1'b1;
        acc_d   = neg_q ? alu_sum[DataW-1:0] : l_q;
        state_d = S_WB;
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m2[PtrW-1:0];
        wr_data = acc_q;
        cnt_d   = cnt_m1;
        state_d = end_state;
      end
      S_FIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_d.status = fin_status;
          out_d.value  = (fin_status == ST_OK) ? rd_data_q : '0;
          cnt_d        = '0;
          err_d        = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      it_q        <= it_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    op_q   <= op_d;
    last_q <= last_d;
    neg_q  <= neg_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
  end

endmodule

// ===== hw/rtl/pfe_checker.sv =====
`include "postfix_expression_evaluator_defines.svh"

module pfe_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_last_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [31:0]      out_value_i,
  input pfe_pkg::status_e        out_status_i
);
  import pfe_pkg::*;

  logic       in_last_fire, out_fire;
  logic [1:0] pend_q;

  assign in_last_fire = in_valid_i && in_ready_i && in_last_i;
  assign out_fire     = out_valid_i && out_ready_i;

  // expressions ended but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_last_fire) - 2'(out_fire);
    end
  end

  `PFE_ASSERT_RST(a_no_result_in_reset, !rst_ni |=> !out_valid_i, "result valid in reset")
  `PFE_ASSERT(a_hold_result, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_status_i), "stalled result changed")
  `PFE_ASSERT(a_zero_on_error, out_valid_i && out_status_i != ST_OK |-> out_value_i == 0, "nonzero value with error")
  `PFE_ASSERT(a_busy_after_last, in_last_fire |=> !in_ready_i, "ready right after last character")
  `PFE_ASSERT(a_result_needs_last, out_fire |-> pend_q != 2'd0, "result without a last character")

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.payload.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.payload.value),
  .out_status_i(out_o.payload.status)
);
